// ----- hdl/ufcb_pkg.sv -----
// Shared types and constants for the update frame to CAN bridge.
package ufcb_pkg;

  localparam int unsigned MaxFrameBytesDef = 2048;
  localparam logic [10:0] CanBaseIdReset = 11'h600;
  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam int unsigned HeadDepth = 10;
  localparam int unsigned StatusLen = 20;

  localparam logic [1:0] KindCan = 2'd0;
  localparam logic [1:0] KindEth = 2'd1;
  localparam logic [1:0] KindFile = 2'd2;

  localparam logic [7:0] TypeHandshake = 8'd1;
  localparam logic [7:0] TypeFileInfo = 8'd2;
  localparam logic [7:0] TypeData = 8'd3;
  localparam logic [7:0] TypeControl = 8'd4;
  localparam logic [7:0] CtrlRestart = 8'd3;

  // Action handed from the parser to the emitter.
  typedef enum logic [1:0] {
    ActHandshake = 2'd0,
    ActFile      = 2'd1,
    ActCan       = 2'd2
  } act_e;

  typedef struct packed {
    act_e        act;
    logic [10:0] can_id;
    logic [3:0]  can_dlc;
    logic [63:0] can_data;
    logic [7:0]  fw_type;
    logic [31:0] fw_addr;
    logic [31:0] fw_size;
    logic [7:0]  target_ctrl;
  } cmd_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

  // Fixed 16-byte handshake status header; the CRC tail comes from the emitter.
  function automatic logic [7:0] status_byte(input logic [4:0] i);
    logic [7:0] r;
    case (i)
      5'd0: r = 8'h46;
      5'd1: r = 8'h57;
      5'd2: r = 8'h55;
      5'd3: r = 8'h50;
      5'd4: r = 8'h05;
      5'd7: r = 8'h01;
      5'd11: r = 8'h04;
      5'd16: r = 8'h00;
      5'd17: r = 8'h00;
      5'd18: r = 8'h00;
      5'd19: r = 8'h00;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/ufcb_parser.sv -----
// Front end: frame parser, CRC check and action classification.
module ufcb_parser import ufcb_pkg::*; #(
  parameter int unsigned MaxFrameBytes = MaxFrameBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        chunk_last_i,
  input  logic [10:0] can_base_id_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  localparam int unsigned PosW = $clog2(MaxFrameBytes + 1);

  typedef enum logic [1:0] {
    PhHeader = 2'd0,
    PhBody   = 2'd1,
    PhDrop   = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]  kind_q, kind_d, ctrl_q, ctrl_d;
  logic [31:0] len_q, len_d, crc_q, crc_d, fcrc_q, fcrc_d;
  logic [7:0]  head_q [HeadDepth];
  logic [7:0]  head_d [HeadDepth];
  logic [7:0]  sft_q, sft_d, uctl_q, uctl_d;
  logic [31:0] ssa_q, ssa_d, ssz_q, ssz_d;
  logic        emit;
  cmd_t        cmd;

  // Stall only when an action is due and the queue is full.
  assign in_ready_o = cmd_ready_i || !emit;
  assign cmd_valid_o = emit && in_valid_i;
  assign cmd_o = cmd;

  always_comb begin
    logic [7:0]  b;
    logic [31:0] q;
    logic [31:0] p;
    logic [15:0] size;
    logic [2:0]  copy;
    logic [10:0] cid;
    b = rx_byte_i;
    phase_d = phase_q; pos_d = pos_q; kind_d = kind_q; ctrl_d = ctrl_q;
    len_d = len_q; crc_d = crc_q; fcrc_d = fcrc_q; head_d = head_q;
    sft_d = sft_q; ssa_d = ssa_q; ssz_d = ssz_q; uctl_d = uctl_q;
    emit = 1'b0;
    cmd = '0;
    cmd.act = ActCan;
    p = 32'(pos_q);
    q = p - 32'd12;
    size = 16'd0;
    copy = 3'd0;
    cid = '0;
    case (phase_q)
      PhHeader: begin
        if (p == 32'd0) begin
          crc_d = '1; fcrc_d = '0; len_d = '0; kind_d = '0; ctrl_d = '0;
          for (int i = 0; i < HeadDepth; i++) head_d[i] = 8'd0;
        end
        if (p < 32'd4 && b != status_byte(pos_q[4:0])) begin
          phase_d = PhDrop;
        end else begin
          crc_d = crc_byte(crc_d, b);
          if (p == 32'd4) kind_d = b;
          if (p == 32'd5) ctrl_d = b;
          if (p >= 32'd8 && p < 32'd12) len_d = {len_d[23:0], b};
          pos_d = pos_q + 1'b1;
          if (p + 32'd1 >= 32'd12) begin
            phase_d = (len_d > 32'(MaxFrameBytes - 16)) ? PhDrop : PhBody;
          end
        end
      end
      PhBody: begin
        if (q < len_q) begin
          crc_d = crc_byte(crc_q, b);
          for (int i = 0; i < HeadDepth; i++) begin
            if (q == 32'(i)) head_d[i] = b;
          end
        end else begin
          fcrc_d = {fcrc_q[23:0], b};
        end
        pos_d = pos_q + 1'b1;
        if (p + 32'd1 >= len_q + 32'd16) begin
          phase_d = PhDrop;
          if (~crc_q == fcrc_d) begin
            cid = can_base_id_i + 11'(ctrl_q);
            cmd.can_id = cid;
            case (kind_q)
              TypeHandshake: begin
                emit = 1'b1;
                cmd.act = ActHandshake;
              end
              TypeFileInfo: begin
                emit = 1'b1;
                if (len_q >= 32'd10) begin
                  sft_d = head_q[0];
                  ssa_d = {head_q[2], head_q[3], head_q[4], head_q[5]};
                  ssz_d = {head_q[6], head_q[7], head_q[8], head_q[9]};
                end
                uctl_d = ctrl_q;
                cmd.act = ActFile;
                cmd.fw_type = sft_d;
                cmd.fw_addr = ssa_d;
                cmd.fw_size = ssz_d;
                cmd.target_ctrl = uctl_d;
                cmd.can_id = '0;
              end
              TypeData: begin
                emit = 1'b1;
                size = {head_q[2], head_q[3]};
                copy = (size > 16'd5) ? 3'd5 : size[2:0];
                cmd.can_dlc = (size > 16'd5) ? 4'd8 : 4'(size[2:0]) + 4'd3;
                cmd.can_data = {8'h36, head_q[0], head_q[1], 40'd0};
                for (int i = 0; i < 5; i++) begin
                  if (3'(i) < copy) cmd.can_data[32-8*i +: 8] = head_q[4+i];
                end
              end
              TypeControl: begin
                if (head_q[1] == CtrlRestart) begin
                  emit = 1'b1;
                  cmd.can_dlc = 4'd3;
                  cmd.can_data = {8'h22, 8'hF1, 8'h90, 40'd0};
                end
              end
              default: emit = 1'b0;
            endcase
          end
        end
      end
      default: ;
    endcase
    if (!emit) begin
      sft_d = sft_q; ssa_d = ssa_q; ssz_d = ssz_q; uctl_d = uctl_q;
    end
    if (chunk_last_i) begin
      phase_d = PhHeader;
      pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader; pos_q <= '0; kind_q <= '0; ctrl_q <= '0;
      len_q <= '0; crc_q <= '1; fcrc_q <= '0;
      for (int i = 0; i < HeadDepth; i++) head_q[i] <= '0;
      sft_q <= '0; ssa_q <= '0; ssz_q <= '0; uctl_q <= '0;
    end else if (in_valid_i && in_ready_o) begin
      phase_q <= phase_d; pos_q <= pos_d; kind_q <= kind_d; ctrl_q <= ctrl_d;
      len_q <= len_d; crc_q <= crc_d; fcrc_q <= fcrc_d; head_q <= head_d;
      sft_q <= sft_d; ssa_q <= ssa_d; ssz_q <= ssz_d; uctl_q <= uctl_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_drop_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o && cmd_ready_i && !chunk_last_i |=> phase_q == PhDrop)
    else $error("parser not in drop after action");
  a_pos_zero_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && chunk_last_i |=> pos_q == '0 && phase_q == PhHeader)
    else $error("chunk end did not rewind");
  a_emit_needs_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o |-> phase_q == PhBody)
    else $error("action outside body");
`endif

endmodule

// ----- hdl/ufcb_queue.sv -----
// Short command queue between parser and emitter.
module ufcb_queue import ufcb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  cmd_t wr_cmd_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output cmd_t rd_cmd_o
);

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_cmd_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_cmd_i;
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count out of range");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && !rd |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue count missed a write");
  a_no_ptr_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rd |=> $stable(rp_q))
    else $error("read pointer moved");
`endif

endmodule

// ----- hdl/ufcb_emitter.sv -----
// Back end: expands commands into result beats.
module ufcb_emitter import ufcb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [10:0] can_id_o,
  output logic [3:0]  can_dlc_o,
  output logic [63:0] can_data_o,
  output logic [7:0]  eth_byte_o,
  output logic        last_of_run_o,
  output logic [7:0]  fw_type_o,
  output logic [31:0] fw_addr_o,
  output logic [31:0] fw_size_o,
  output logic [7:0]  target_ctrl_o
);

  logic [4:0] idx_q;
  logic       hs;
  logic       done;

  // CRC of the fixed 16-byte status header, big-endian, worked out at elaboration.
  function automatic logic [7:0] crc_tail(input logic [1:0] k);
    logic [31:0] c;
    c = '1;
    for (int i = 0; i < 16; i++) c = crc_byte(c, status_byte(5'(i)));
    c = ~c;
    return c[31 - 8*k -: 8];
  endfunction

  assign hs = cmd_i.act == ActHandshake;
  assign out_valid_o = cmd_valid_i;
  assign done = !hs || idx_q == 5'(StatusLen - 1);
  assign cmd_ready_o = out_ready_i && done;

  always_comb begin
    out_kind_o = KindCan; can_id_o = '0; can_dlc_o = '0; can_data_o = '0;
    eth_byte_o = '0; fw_type_o = '0; fw_addr_o = '0; fw_size_o = '0;
    target_ctrl_o = '0;
    last_of_run_o = done;
    case (cmd_i.act)
      ActHandshake: begin
        out_kind_o = KindEth;
        eth_byte_o = status_byte(idx_q);
        case (idx_q)
          5'd16: eth_byte_o = 8'h00;
          default: ;
        endcase
        if (idx_q >= 5'd16) eth_byte_o = crc_tail(idx_q[1:0]);
      end
      ActFile: begin
        out_kind_o = KindFile;
        fw_type_o = cmd_i.fw_type; fw_addr_o = cmd_i.fw_addr;
        fw_size_o = cmd_i.fw_size; target_ctrl_o = cmd_i.target_ctrl;
      end
      default: begin
        can_id_o = cmd_i.can_id; can_dlc_o = cmd_i.can_dlc;
        can_data_o = cmd_i.can_data;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (out_valid_o && out_ready_i && hs) begin
      idx_q <= done ? 5'd0 : idx_q + 5'd1;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < 5'(StatusLen))
    else $error("status index out of range");
  a_idx_zero_nonhs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && !hs |-> idx_q == 5'd0)
    else $error("stale status index");
  a_last_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_of_run_o |-> cmd_ready_o)
    else $error("last beat without pop");
`endif

endmodule

// ----- hdl/update_frame_to_can_bridge_unit.sv -----
// Results: a frame's action enters the command queue when its last CRC byte is
// accepted. Throughput: one input byte per cycle; a handshake emits 20 beats, one
// per cycle while out_ready_i is high, others one beat; a two-entry command queue
// decouples the parser from the output. The input stalls only when an action is
// due while the queue is full. Reset: asynchronous, active low; parser at header
// start, base id 0x600. Top level of the update frame to CAN bridge.
module update_frame_to_can_bridge_unit import ufcb_pkg::*; #(
  parameter int unsigned MaxFrameBytes = MaxFrameBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] can_base_id_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        chunk_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [10:0] can_id_o,
  output logic [3:0]  can_dlc_o,
  output logic [63:0] can_data_o,
  output logic [7:0]  eth_byte_o,
  output logic        last_of_run_o,
  output logic [7:0]  fw_type_o,
  output logic [31:0] fw_addr_o,
  output logic [31:0] fw_size_o,
  output logic [7:0]  target_ctrl_o
);

  logic [10:0] base_q;
  logic        pv, pr, qv, qr;
  cmd_t        pc, qc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) base_q <= CanBaseIdReset;
    else if (cfg_valid_i) base_q <= can_base_id_i;
  end

  ufcb_parser #(.MaxFrameBytes(MaxFrameBytes)) u_parser (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .rx_byte_i, .chunk_last_i,
    .can_base_id_i(base_q), .cmd_valid_o(pv), .cmd_ready_i(pr), .cmd_o(pc)
  );

  ufcb_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(pv), .wr_ready_o(pr), .wr_cmd_i(pc),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_cmd_o(qc)
  );

  ufcb_emitter u_emitter (
    .clk_i, .rst_ni, .cmd_valid_i(qv), .cmd_ready_o(qr), .cmd_i(qc),
    .out_valid_o, .out_ready_i, .out_kind_o, .can_id_o, .can_dlc_o, .can_data_o,
    .eth_byte_o, .last_of_run_o, .fw_type_o, .fw_addr_o, .fw_size_o,
    .target_ctrl_o
  );

endmodule
